>>> rtl/cosine_topk_vector_search_unit_assert.svh
// Assertion macros for the cosine top-k search unit.
`ifndef COSINE_TOPK_VECTOR_SEARCH_UNIT_ASSERT_SVH
`define COSINE_TOPK_VECTOR_SEARCH_UNIT_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define CTVS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("ctvs assertion failed");

// Condition a implies condition b in the next cycle.
`define CTVS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("ctvs assertion failed");

`endif

>>> rtl/ctvs_pkg.sv
// Shared constants and types of the cosine top-k search unit.
`timescale 1ns / 1ps
package ctvs_pkg;
    localparam int MAX_ENTRIES = 64;
    localparam int MAX_DIM     = 256;
    localparam int ELEM_W      = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int COL_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int BANK_AW     = IDX_W + COL_W;
    localparam int SQ_W        = 40;
    localparam int RAD_W       = SQ_W + 16;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int QUO_W       = 49;
    localparam int INV_W       = 41;
    localparam int NPROD_W     = ELEM_W + INV_W;
    localparam int SCORE_W     = 32;
    localparam int ACC_W       = 2 * ELEM_W + COL_W;
    localparam int TOPK_W      = 7;
    localparam int STATUS_W    = 3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIM_MISS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic              is_query;
        logic [DIM_W-1:0]  n;
        logic              too_long;
        logic [SQ_W-1:0]   sq;
        logic [TOPK_W-1:0] top_k;
    } t_job;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [IDX_W-1:0]         idx;
        logic signed [SCORE_W-1:0] score;
        logic                     fin;
    } t_result;
endpackage

>>> rtl/ctvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ctvs_ram #(
    parameter int W = 16,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/ctvs_front.sv
// Input side: stages elements, sums their squares and issues one job per vector.
`timescale 1ns / 1ps
module ctvs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_cmd,
    input  logic signed [ctvs_pkg::ELEM_W-1:0] i_elem_value,
    input  logic                          i_elem_last,
    input  logic [ctvs_pkg::TOPK_W-1:0]   i_top_k,
    output logic                          o_stg_we,
    output logic [ctvs_pkg::COL_W-1:0]    o_stg_addr,
    output logic [ctvs_pkg::ELEM_W-1:0]   o_stg_data,
    output logic                          o_job_push,
    output ctvs_pkg::t_job                o_job,
    input  logic                          i_job_full,
    input  logic                          i_release
);
    import ctvs_pkg::*;

    logic [DIM_W-1:0]   r_count;
    logic [SQ_W-1:0]    r_sq;
    logic               r_too_long;
    logic               r_lock;
    logic               accept;
    logic               in_range;
    logic [ELEM_W-1:0]  mag;
    logic [2*ELEM_W-1:0] sq;
    logic [SQ_W:0]      sum;
    logic [SQ_W-1:0]    n_sq;
    logic [DIM_W-1:0]   n_count;
    logic               n_too_long;

    // The staging store stays locked from a vector's last element until the
    // back end has finished reading it.
    assign o_full   = r_lock | i_job_full;
    assign accept   = i_push & ~o_full;
    assign in_range = r_count < DIM_W'(MAX_DIM);
    assign mag      = i_elem_value[ELEM_W-1] ? (~i_elem_value + ELEM_W'(1)) : i_elem_value;
    assign sq       = mag * mag;
    assign sum      = {1'b0, r_sq} + (SQ_W + 1)'(sq);

    always_comb begin
        n_sq       = r_sq;
        n_count    = r_count;
        n_too_long = r_too_long;
        if (in_range) begin
            n_sq    = sum[SQ_W] ? {SQ_W{1'b1}} : sum[SQ_W-1:0];
            n_count = r_count + DIM_W'(1);
        end else begin
            n_too_long = 1'b1;
        end
    end

    assign o_stg_we   = accept & in_range;
    assign o_stg_addr = r_count[COL_W-1:0];
    assign o_stg_data = i_elem_value;

    assign o_job_push     = accept & i_elem_last;
    assign o_job.is_query = i_cmd;
    assign o_job.n        = n_count;
    assign o_job.too_long = n_too_long;
    assign o_job.sq       = n_sq;
    assign o_job.top_k    = i_top_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sq       <= '0;
            r_too_long <= 1'b0;
            r_lock     <= 1'b0;
        end else begin
            if (i_release) begin
                r_lock <= 1'b0;
            end
            if (accept) begin
                if (i_elem_last) begin
                    r_count    <= '0;
                    r_sq       <= '0;
                    r_too_long <= 1'b0;
                    r_lock     <= 1'b1;
                end else begin
                    r_count    <= n_count;
                    r_sq       <= n_sq;
                    r_too_long <= n_too_long;
                end
            end
        end
    end
endmodule

>>> rtl/ctvs_queue.sv
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
module ctvs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ctvs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output ctvs_pkg::t_job o_job,
    output logic           o_empty
);
    import ctvs_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

>>> rtl/ctvs_back.sv
// Execution side: normalization, bank writes, dot products and top-k selection.
`timescale 1ns / 1ps
module ctvs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ctvs_pkg::t_job                i_job,
    input  logic                          i_job_empty,
    output logic                          o_job_pop,
    output logic                          o_release,
    output logic [ctvs_pkg::COL_W-1:0]    o_stg_raddr,
    input  logic [ctvs_pkg::ELEM_W-1:0]   i_stg_rdata,
    output logic                          o_empty,
    input  logic                          i_pop,
    output ctvs_pkg::t_result             o_result
);
    import ctvs_pkg::*;
    `include "cosine_topk_vector_search_unit_assert.svh"

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CHECK   = 5'd1;
    localparam logic [4:0] S_SQRT    = 5'd2;
    localparam logic [4:0] S_DIV     = 5'd3;
    localparam logic [4:0] S_N_RD    = 5'd4;
    localparam logic [4:0] S_N_MUL   = 5'd5;
    localparam logic [4:0] S_N_WR    = 5'd6;
    localparam logic [4:0] S_ADD_OUT = 5'd7;
    localparam logic [4:0] S_D_RD    = 5'd8;
    localparam logic [4:0] S_D_MUL   = 5'd9;
    localparam logic [4:0] S_D_ACC   = 5'd10;
    localparam logic [4:0] S_D_SAT   = 5'd11;
    localparam logic [4:0] S_K_INIT  = 5'd12;
    localparam logic [4:0] S_K_START = 5'd13;
    localparam logic [4:0] S_K_RD    = 5'd14;
    localparam logic [4:0] S_K_CMP   = 5'd15;
    localparam logic [4:0] S_K_OUT   = 5'd16;
    localparam logic [4:0] S_ERR_OUT = 5'd17;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

    logic [4:0]                r_state;
    t_job                      r_job;
    logic [CNT_W-1:0]          r_entry_count;
    logic [DIM_W-1:0]          r_bank_dim;
    logic [STATUS_W-1:0]       r_err;
    logic [RAD_W-1:0]          r_rem;
    logic [RAD_W-1:0]          r_res;
    logic [RAD_W-1:0]          r_bit;
    logic [ROOT_W-1:0]         r_drem;
    logic [QUO_W-1:0]          r_dq;
    logic [5:0]                r_step;
    logic [INV_W-1:0]          r_inv;
    logic [DIM_W-1:0]          r_col;
    logic [CNT_W-1:0]          r_row;
    logic [NPROD_W-1:0]        r_nprod;
    logic                      r_neg;
    logic signed [2*ELEM_W-1:0] r_dprod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [MAX_ENTRIES-1:0]    r_used;
    logic [CNT_W-1:0]          r_take;
    logic [CNT_W-1:0]          r_emitted;
    logic [CNT_W-1:0]          r_j;
    logic                      r_found;
    logic [IDX_W-1:0]          r_best;
    logic signed [SCORE_W-1:0] r_best_score;
    logic                      r_out_valid;
    t_result                   r_out;

    logic                      out_free;
    logic                      load;
    t_result                   n_out;
    logic [STATUS_W-1:0]       chk;
    logic [RAD_W-1:0]          sq_try;
    logic                      sq_ge;
    logic [ROOT_W:0]           div_rem2;
    logic                      div_ge;
    logic [QUO_W-1:0]          n_dq;
    logic [ELEM_W-1:0]         mag;
    logic [NPROD_W:0]          rnd;
    logic [NPROD_W-25:0]       y;
    logic [ELEM_W-1:0]         nval;
    logic                      bank_we;
    logic                      q_we;
    logic                      score_we;
    logic [ELEM_W-1:0]         bank_rd;
    logic [ELEM_W-1:0]         q_rd;
    logic [SCORE_W-1:0]        score_rd;
    logic signed [SCORE_W-1:0] sat_score;
    logic                      last_col;
    logic                      last_row;
    logic                      last_j;
    logic                      pick;
    logic                      k_final;

    assign out_free = ~r_out_valid | i_pop;

    // Error checks, in the order the two commands define.
    always_comb begin
        chk = ST_OK;
        if (!r_job.is_query) begin
            if (r_job.too_long) begin
                chk = ST_TOO_LONG;
            end else if (r_bank_dim != '0 && r_job.n != r_bank_dim) begin
                chk = ST_DIM_MISS;
            end else if (r_entry_count >= CNT_W'(MAX_ENTRIES)) begin
                chk = ST_FULL;
            end
        end else begin
            if (r_job.too_long) begin
                chk = ST_TOO_LONG;
            end else if (r_entry_count == '0) begin
                chk = ST_EMPTY;
            end else if (r_job.n != r_bank_dim) begin
                chk = ST_DIM_MISS;
            end
        end
    end

    // One result bit of the square root and one quotient bit per cycle.
    assign sq_try   = r_res + r_bit;
    assign sq_ge    = r_rem >= sq_try;
    assign div_rem2 = {r_drem, r_step == 6'd0};
    assign div_ge   = div_rem2 >= {1'b0, r_res[ROOT_W-1:0]};
    assign n_dq     = {r_dq[QUO_W-2:0], div_ge};

    assign mag  = i_stg_rdata[ELEM_W-1] ? (~i_stg_rdata + ELEM_W'(1)) : i_stg_rdata;
    assign rnd  = {1'b0, r_nprod} + (NPROD_W + 1)'(1 << 24);
    assign y    = rnd[NPROD_W:25];

    always_comb begin
        if (r_neg) begin
            nval = (y > (NPROD_W - 24)'(32768)) ? 16'h8000 : (~y[ELEM_W-1:0] + ELEM_W'(1));
        end else begin
            nval = (y > (NPROD_W - 24)'(32767)) ? 16'h7fff : y[ELEM_W-1:0];
        end
    end

    always_comb begin
        if (r_acc > SAT_MAX) begin
            sat_score = SAT_MAX[SCORE_W-1:0];
        end else if (r_acc < SAT_MIN) begin
            sat_score = SAT_MIN[SCORE_W-1:0];
        end else begin
            sat_score = r_acc[SCORE_W-1:0];
        end
    end

    assign last_col = (r_col + DIM_W'(1)) == r_job.n;
    assign last_row = (r_row + CNT_W'(1)) == r_entry_count;
    assign last_j   = (r_j + CNT_W'(1)) == r_entry_count;
    assign pick     = ~r_used[r_j[IDX_W-1:0]]
                      & (~r_found | ($signed(score_rd) > r_best_score));
    assign k_final  = (r_emitted + CNT_W'(1)) == r_take;

    assign bank_we  = (r_state == S_N_WR) & ~r_job.is_query;
    assign q_we     = (r_state == S_N_WR) & r_job.is_query;
    assign score_we = r_state == S_D_SAT;

    always_comb begin
        load  = 1'b0;
        n_out = r_out;
        case (r_state)
            S_ADD_OUT: begin
                load  = out_free;
                n_out = '{ST_OK, r_entry_count[IDX_W-1:0], '0, 1'b1};
            end
            S_K_OUT: begin
                load  = out_free;
                n_out = '{ST_OK, r_best, r_best_score, k_final};
            end
            S_ERR_OUT: begin
                load  = out_free;
                n_out = '{r_err, '0, '0, 1'b1};
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign o_job_pop   = (r_state == S_IDLE) & ~i_job_empty;
    assign o_release   = ((r_state == S_CHECK) & (chk != ST_OK))
                         | ((r_state == S_N_WR) & last_col);
    assign o_stg_raddr = r_col[COL_W-1:0];
    assign o_empty     = ~r_out_valid;
    assign o_result    = r_out;

    ctvs_ram #(.W(ELEM_W), .D(MAX_ENTRIES * MAX_DIM)) u_bank (
        .i_clk   (i_clk),
        .i_we    (bank_we),
        .i_waddr ({r_entry_count[IDX_W-1:0], r_col[COL_W-1:0]}),
        .i_wdata (nval),
        .i_raddr ({r_row[IDX_W-1:0], r_col[COL_W-1:0]}),
        .o_rdata (bank_rd)
    );

    ctvs_ram #(.W(ELEM_W), .D(MAX_DIM)) u_qvec (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_col[COL_W-1:0]),
        .i_wdata (nval),
        .i_raddr (r_col[COL_W-1:0]),
        .o_rdata (q_rd)
    );

    ctvs_ram #(.W(SCORE_W), .D(MAX_ENTRIES)) u_score (
        .i_clk   (i_clk),
        .i_we    (score_we),
        .i_waddr (r_row[IDX_W-1:0]),
        .i_wdata (sat_score),
        .i_raddr (r_j[IDX_W-1:0]),
        .o_rdata (score_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_bank_dim    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_col <= '0;
                    r_err <= chk;
                    r_rem <= {r_job.sq, 16'b0};
                    r_res <= '0;
                    r_bit <= RAD_W'(1) << (RAD_W - 2);
                    if (chk != ST_OK) begin
                        r_state <= S_ERR_OUT;
                    end else if (r_job.sq == '0) begin
                        // An all-zero vector: a zero scale keeps every element zero.
                        r_inv   <= '0;
                        r_state <= S_N_RD;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_rem <= r_rem - sq_try;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == RAD_W'(1)) begin
                        r_drem  <= '0;
                        r_dq    <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_drem <= div_ge ? ROOT_W'(div_rem2 - {1'b0, r_res[ROOT_W-1:0]})
                                     : div_rem2[ROOT_W-1:0];
                    r_dq   <= n_dq;
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(QUO_W - 1)) begin
                        r_inv   <= n_dq[INV_W-1:0];
                        r_state <= S_N_RD;
                    end
                end
                S_N_RD: begin
                    r_state <= S_N_MUL;
                end
                S_N_MUL: begin
                    r_nprod <= mag * r_inv;
                    r_neg   <= i_stg_rdata[ELEM_W-1];
                    r_state <= S_N_WR;
                end
                S_N_WR: begin
                    r_col <= r_col + DIM_W'(1);
                    if (!last_col) begin
                        r_state <= S_N_RD;
                    end else if (!r_job.is_query) begin
                        r_state <= S_ADD_OUT;
                    end else begin
                        r_col   <= '0;
                        r_row   <= '0;
                        r_acc   <= '0;
                        r_state <= S_D_RD;
                    end
                end
                S_ADD_OUT: begin
                    if (out_free) begin
                        r_entry_count <= r_entry_count + CNT_W'(1);
                        r_bank_dim    <= r_job.n;
                        r_state       <= S_IDLE;
                    end
                end
                S_D_RD: begin
                    r_state <= S_D_MUL;
                end
                S_D_MUL: begin
                    r_dprod <= $signed(bank_rd) * $signed(q_rd);
                    r_state <= S_D_ACC;
                end
                S_D_ACC: begin
                    r_acc <= r_acc + ACC_W'(r_dprod);
                    if (last_col) begin
                        r_state <= S_D_SAT;
                    end else begin
                        r_col   <= r_col + DIM_W'(1);
                        r_state <= S_D_RD;
                    end
                end
                S_D_SAT: begin
                    r_row <= r_row + CNT_W'(1);
                    r_col <= '0;
                    r_acc <= '0;
                    r_state <= last_row ? S_K_INIT : S_D_RD;
                end
                S_K_INIT: begin
                    r_take    <= (r_job.top_k == '0 || CNT_W'(r_job.top_k) > r_entry_count)
                                 ? r_entry_count : CNT_W'(r_job.top_k);
                    r_emitted <= '0;
                    r_used    <= '0;
                    r_state   <= S_K_START;
                end
                S_K_START: begin
                    r_j     <= '0;
                    r_found <= 1'b0;
                    r_state <= S_K_RD;
                end
                S_K_RD: begin
                    r_state <= S_K_CMP;
                end
                S_K_CMP: begin
                    // A strictly higher score wins, so ties keep the lower index.
                    if (pick) begin
                        r_found      <= 1'b1;
                        r_best       <= r_j[IDX_W-1:0];
                        r_best_score <= $signed(score_rd);
                    end
                    r_j     <= r_j + CNT_W'(1);
                    r_state <= last_j ? S_K_OUT : S_K_RD;
                end
                S_K_OUT: begin
                    if (out_free) begin
                        r_used[r_best] <= 1'b1;
                        r_emitted      <= r_emitted + CNT_W'(1);
                        r_state        <= k_final ? S_IDLE : S_K_START;
                    end
                end
                S_ERR_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CTVS_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, load, !r_out_valid || i_pop)
    `CTVS_ASSERT_IMPLY(a_err_final, i_clk, i_rst_n, r_out_valid && r_out.status != ST_OK, r_out.fin)
    `CTVS_ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, 1'b1, r_entry_count <= CNT_W'(MAX_ENTRIES))
    `CTVS_ASSERT_NEXT(a_pop_check, i_clk, i_rst_n, o_job_pop, r_state == S_CHECK)
endmodule

>>> rtl/cosine_topk_vector_search_unit.sv
// Top level of the brute-force cosine top-k vector search unit.
//
//  channel  | direction | handshake     | payload
//  input    | in        | i_push/o_full | i_cmd, i_elem_value, i_elem_last, i_top_k
//  result   | out       | o_empty/i_pop | o_status, o_entry_index, o_score, o_final_result
//
// Elements are taken one per cycle while o_full is low; a final element hands a job to the back end.
// A job takes the root and the reciprocal of its squared norm and then normalizes its n elements,
// and a query then adds dot products against every stored entry and one selection scan over
// all entries per result, stepping through one element or entry at a time.
// Input stalls from a final element until the back end has read the staged vector.
// Synchronous active-low reset; the bank needs no clearing pass.
`timescale 1ns / 1ps
module cosine_topk_vector_search_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic                                i_cmd,
    input  logic signed [ctvs_pkg::ELEM_W-1:0]  i_elem_value,
    input  logic                                i_elem_last,
    input  logic [ctvs_pkg::TOPK_W-1:0]         i_top_k,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [ctvs_pkg::STATUS_W-1:0]       o_status,
    output logic [ctvs_pkg::IDX_W-1:0]          o_entry_index,
    output logic signed [ctvs_pkg::SCORE_W-1:0] o_score,
    output logic                                o_final_result
);
    import ctvs_pkg::*;

    logic              stg_we;
    logic [COL_W-1:0]  stg_waddr;
    logic [ELEM_W-1:0] stg_wdata;
    logic [COL_W-1:0]  stg_raddr;
    logic [ELEM_W-1:0] stg_rdata;
    logic              job_push;
    t_job              job_in;
    t_job              job_out;
    logic              job_full;
    logic              job_empty;
    logic              job_pop;
    logic              release_stg;
    t_result           result;

    ctvs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_cmd        (i_cmd),
        .i_elem_value (i_elem_value),
        .i_elem_last  (i_elem_last),
        .i_top_k      (i_top_k),
        .o_stg_we     (stg_we),
        .o_stg_addr   (stg_waddr),
        .o_stg_data   (stg_wdata),
        .o_job_push   (job_push),
        .o_job        (job_in),
        .i_job_full   (job_full),
        .i_release    (release_stg)
    );

    ctvs_ram #(.W(ELEM_W), .D(MAX_DIM)) u_staging (
        .i_clk   (i_clk),
        .i_we    (stg_we),
        .i_waddr (stg_waddr),
        .i_wdata (stg_wdata),
        .i_raddr (stg_raddr),
        .o_rdata (stg_rdata)
    );

    ctvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    ctvs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_release   (release_stg),
        .o_stg_raddr (stg_raddr),
        .i_stg_rdata (stg_rdata),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (result)
    );

    assign o_status       = result.status;
    assign o_entry_index  = result.idx;
    assign o_score        = result.score;
    assign o_final_result = result.fin;
endmodule
